>>> rtl/core/bde_pkg.sv
// Shared types, sizes and ring-pointer helpers for the bounded deque engine.
// Depends on nothing; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps

package bde_pkg;

	// Number of entries in the ring store.
	localparam int DEPTH = 16;

	// Width of a ring index and of an occupancy count (0..DEPTH).
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int SUM_W = CNT_W + 1;

	// Data word width.
	localparam int DATA_W = 32;

	// Command queue between the front and the back.
	localparam int CMDQ_DEPTH = 2;
	localparam int CQ_PTR_W   = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
	localparam int CQ_CNT_W   = $clog2(CMDQ_DEPTH + 1);

	// Request codes as they appear on the request channel.
	typedef enum logic [2:0] {
		OP_INS_FRONT = 3'd0,
		OP_INS_BACK  = 3'd1,
		OP_DEL_FRONT = 3'd2,
		OP_DEL_BACK  = 3'd3,
		OP_DISPLAY   = 3'd4
	} op_t;

	// Result status codes.
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_EMPTY = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;

	// One classified command held in the queue.
	typedef struct packed {
		op_t                       op;
		logic signed [DATA_W-1:0]  value;
	} cmd_t;

	// Handshake between the front and the command queue.
	typedef struct packed {
		logic push;
		cmd_t cmd;
	} cmd_push_t;

	// Next ring index, wrapping at DEPTH.
	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == PTR_W'(DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + PTR_W'(1);
		end
		return r;
	endfunction

	// Previous ring index, wrapping at zero.
	function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == '0) begin
			r = PTR_W'(DEPTH - 1);
		end else begin
			r = p - PTR_W'(1);
		end
		return r;
	endfunction

	// Ring index p advanced by c places; c never exceeds DEPTH - 1 here.
	function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] p,
			input logic [CNT_W-1:0] c);
		logic [SUM_W-1:0] s;
		s = SUM_W'(p) + SUM_W'(c);
		if (s >= SUM_W'(DEPTH)) begin
			s = s - SUM_W'(DEPTH);
		end
		return s[PTR_W-1:0];
	endfunction

endpackage

>>> rtl/core/bde_if.sv
// Valid/ready channel interfaces for requests and results of the deque engine.
// Depends on bde_pkg for the data width.
`timescale 1ns / 1ps

interface bde_req_if;
	logic                              valid;
	logic                              ready;
	logic [2:0]                        req_type;
	logic signed [bde_pkg::DATA_W-1:0] item_value;

	modport source (output valid, output req_type, output item_value, input ready);
	modport sink (input valid, input req_type, input item_value, output ready);
endinterface

interface bde_rsp_if;
	logic                              valid;
	logic                              ready;
	logic [1:0]                        status;
	logic signed [bde_pkg::DATA_W-1:0] out_value;
	logic                              last_result;

	modport source (output valid, output status, output out_value, output last_result,
		input ready);
	modport sink (input valid, input status, input out_value, input last_result,
		output ready);
endinterface

>>> rtl/core/bounded_deque_engine_core.sv
// Top level of the bounded deque engine: front end, command queue and back end.
// Depends on bde_pkg, bde_if, bde_front, bde_cmd_fifo and bde_back.
`timescale 1ns / 1ps

// Usage:
// The req channel carries one request word: req_type (insert front, insert back,
// delete front, delete back, display) and item_value, used by inserts only.
// Unused request codes are accepted and dropped without a result.
// The rsp channel carries result words: status, out_value and last_result.
// Inserts and deletes give one result word; a display gives one word per stored
// entry, front to back, or a single empty word when the deque holds nothing.
// The last word of each request has last_result set.
// An insert or delete result word passes the command queue and the result register;
// the first word of a display also passes the registered read of the ring store.
// Inserts and deletes sustain one request per cycle while the receiver takes each
// result; a display holds the back end for the fetch of the front entry and then
// for one store read per stored entry, as the ring store has a single read port.
// A two-entry command queue lets requests be taken while the back end is busy.
// When the receiver stalls, the result register holds its word, the back end
// waits, and the request side backs up once the command queue fills.
// Reset empties the deque and the queue; no clearing pass is needed.
module bounded_deque_engine_core (
	input  logic       clk,
	input  logic       arst_n,
	bde_req_if.sink    req,
	bde_rsp_if.source  rsp
);

	bde_pkg::cmd_push_t  cmd_push;
	logic                cmd_full;
	logic                cmd_valid;
	bde_pkg::cmd_t       cmd;
	logic                cmd_pop;

	// Request classification.
	bde_front u_front (
		.req      (req),
		.cmd_full (cmd_full),
		.cmd_push (cmd_push)
	);

	// Decoupling queue.
	bde_cmd_fifo u_cmd_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_push  (cmd_push),
		.full      (cmd_full),
		.pop_valid (cmd_valid),
		.pop_cmd   (cmd),
		.pop       (cmd_pop)
	);

	// Deque execution.
	bde_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.rsp       (rsp)
	);

`ifndef SYNTHESIS
	// A failed or empty result is always a single, final word with a zero value.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (rsp.status != bde_pkg::STAT_OK) |-> rsp.last_result
			&& (rsp.out_value == '0))
		else $error("non-ok result is not a final zero word");

	// Only a display walk produces words that are not final, and those are ok.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.last_result |-> (rsp.status == bde_pkg::STAT_OK))
		else $error("non-final result word with a non-ok status");

	// The display walk delivers its next word right after a word is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.ready && !rsp.last_result |=> rsp.valid)
		else $error("display walk stalled between words");

	// A command is only taken from the queue when the queue holds one.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> cmd_valid)
		else $error("command popped from an empty queue");
`endif

endmodule

>>> rtl/core/bde_front.sv
// Request front end: accepts request words, drops unused codes, queues commands.
// Depends on bde_pkg and bde_req_if.
`timescale 1ns / 1ps

module bde_front (
	bde_req_if.sink                 req,
	input  logic                    cmd_full,
	output bde_pkg::cmd_push_t      cmd_push
);

	logic code_ok;

	// Only the five defined request codes reach the back end.
	always_comb begin
		case (req.req_type)
			bde_pkg::OP_INS_FRONT,
			bde_pkg::OP_INS_BACK,
			bde_pkg::OP_DEL_FRONT,
			bde_pkg::OP_DEL_BACK,
			bde_pkg::OP_DISPLAY: code_ok = 1'b1;
			default:             code_ok = 1'b0;
		endcase
	end

	// A word is taken whenever the queue has room; unused codes are swallowed.
	assign req.ready           = !cmd_full;
	assign cmd_push.push       = req.valid && !cmd_full && code_ok;
	assign cmd_push.cmd.op     = bde_pkg::op_t'(req.req_type);
	assign cmd_push.cmd.value  = req.item_value;

endmodule

>>> rtl/core/bde_cmd_fifo.sv
// Short command queue that decouples the request front end from the back end.
// Depends on bde_pkg.
`timescale 1ns / 1ps

module bde_cmd_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bde_pkg::cmd_push_t   cmd_push,
	output logic                 full,
	output logic                 pop_valid,
	output bde_pkg::cmd_t        pop_cmd,
	input  logic                 pop
);

	bde_pkg::cmd_t                   slot_q [bde_pkg::CMDQ_DEPTH];
	logic [bde_pkg::CQ_PTR_W-1:0]    wr_ptr_q;
	logic [bde_pkg::CQ_PTR_W-1:0]    rd_ptr_q;
	logic [bde_pkg::CQ_CNT_W-1:0]    cnt_q;
	logic                            do_pop;

	assign full      = (cnt_q == bde_pkg::CQ_CNT_W'(bde_pkg::CMDQ_DEPTH));
	assign pop_valid = (cnt_q != '0);
	assign pop_cmd   = slot_q[rd_ptr_q];
	assign do_pop    = pop && pop_valid;

	// Storage slots hold payload only.
	always_ff @(posedge clk) begin
		if (cmd_push.push) begin
			slot_q[wr_ptr_q] <= cmd_push.cmd;
		end
	end

	// Pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (cmd_push.push) begin
				wr_ptr_q <= (wr_ptr_q == bde_pkg::CQ_PTR_W'(bde_pkg::CMDQ_DEPTH - 1))
					? '0 : wr_ptr_q + bde_pkg::CQ_PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == bde_pkg::CQ_PTR_W'(bde_pkg::CMDQ_DEPTH - 1))
					? '0 : rd_ptr_q + bde_pkg::CQ_PTR_W'(1);
			end
			if (cmd_push.push && !do_pop) begin
				cnt_q <= cnt_q + bde_pkg::CQ_CNT_W'(1);
			end else if (do_pop && !cmd_push.push) begin
				cnt_q <= cnt_q - bde_pkg::CQ_CNT_W'(1);
			end
		end
	end

endmodule

>>> rtl/core/bde_back.sv
// Deque back end: ring store, front pointer, count, display walk and result register.
// Depends on bde_pkg and bde_rsp_if.
`timescale 1ns / 1ps

module bde_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	input  bde_pkg::cmd_t    cmd,
	output logic             cmd_pop,
	bde_rsp_if.source        rsp
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_DISP = 2'b10
	} state_t;

	state_t                               state_q, state_d;
	logic [bde_pkg::PTR_W-1:0]            front_q, front_d;
	logic [bde_pkg::CNT_W-1:0]            count_q, count_d;
	logic [bde_pkg::CNT_W-1:0]            rem_q, rem_d;
	logic [bde_pkg::PTR_W-1:0]            disp_addr_q;
	logic signed [bde_pkg::DATA_W-1:0]    mem [bde_pkg::DEPTH];
	logic signed [bde_pkg::DATA_W-1:0]    rd_data_q;

	logic                                 rsp_valid_q;
	logic [1:0]                           rsp_status_q;
	logic signed [bde_pkg::DATA_W-1:0]    rsp_value_q;
	logic                                 rsp_last_q;

	logic                                 slot_free;
	logic                                 is_full, is_empty;
	logic                                 wr_en, rd_en;
	logic [bde_pkg::PTR_W-1:0]            wr_addr, rd_addr;
	logic                                 emit;
	logic [1:0]                           emit_status;
	logic signed [bde_pkg::DATA_W-1:0]    emit_value;
	logic                                 emit_last;

	assign slot_free = !rsp_valid_q || rsp.ready;
	assign is_full   = (count_q == bde_pkg::CNT_W'(bde_pkg::DEPTH));
	assign is_empty  = (count_q == '0);
	assign cmd_pop   = (state_q == S_IDLE) && cmd_valid && slot_free;

	// Command execution and the display walk.
	always_comb begin
		state_d     = state_q;
		front_d     = front_q;
		count_d     = count_q;
		rem_d       = rem_q;
		wr_en       = 1'b0;
		wr_addr     = front_q;
		rd_en       = 1'b0;
		rd_addr     = front_q;
		emit        = 1'b0;
		emit_status = bde_pkg::STAT_OK;
		emit_value  = '0;
		emit_last   = 1'b1;
		case (state_q)
			S_IDLE: begin
				if (cmd_pop) begin
					emit = 1'b1;
					case (cmd.op)
						bde_pkg::OP_INS_FRONT: begin
							if (is_full) begin
								emit_status = bde_pkg::STAT_FULL;
							end else begin
								wr_en   = 1'b1;
								wr_addr = bde_pkg::ptr_dec(front_q);
								front_d = wr_addr;
								count_d = count_q + bde_pkg::CNT_W'(1);
							end
						end
						bde_pkg::OP_INS_BACK: begin
							if (is_full) begin
								emit_status = bde_pkg::STAT_FULL;
							end else begin
								wr_en   = 1'b1;
								wr_addr = bde_pkg::ptr_add(front_q, count_q);
								count_d = count_q + bde_pkg::CNT_W'(1);
							end
						end
						bde_pkg::OP_DEL_FRONT: begin
							if (is_empty) begin
								emit_status = bde_pkg::STAT_EMPTY;
							end else begin
								front_d = bde_pkg::ptr_inc(front_q);
								count_d = count_q - bde_pkg::CNT_W'(1);
							end
						end
						bde_pkg::OP_DEL_BACK: begin
							if (is_empty) begin
								emit_status = bde_pkg::STAT_EMPTY;
							end else begin
								count_d = count_q - bde_pkg::CNT_W'(1);
							end
						end
						bde_pkg::OP_DISPLAY: begin
							if (is_empty) begin
								emit_status = bde_pkg::STAT_EMPTY;
							end else begin
								// Start the walk: fetch the front entry now.
								emit    = 1'b0;
								rd_en   = 1'b1;
								rd_addr = front_q;
								rem_d   = count_q - bde_pkg::CNT_W'(1);
								state_d = S_DISP;
							end
						end
						default: begin
							emit = 1'b0;
						end
					endcase
				end
			end
			S_DISP: begin
				// When the result slot is free, hand out the fetched entry and fetch the next one, if any, in the same cycle.
				if (slot_free) begin
					emit       = 1'b1;
					emit_value = rd_data_q;
					emit_last  = (rem_q == '0);
					if (rem_q == '0) begin
						state_d = S_IDLE;
					end else begin
						rem_d   = rem_q - bde_pkg::CNT_W'(1);
						rd_en   = 1'b1;
						rd_addr = bde_pkg::ptr_inc(disp_addr_q);
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Ring store with one write port and one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= cmd.value;
		end
		if (rd_en) begin
			rd_data_q   <= mem[rd_addr];
			disp_addr_q <= rd_addr;
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			front_q     <= '0;
			count_q     <= '0;
			rem_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			front_q <= front_d;
			count_q <= count_d;
			rem_q   <= rem_d;
			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Result payload register.
	always_ff @(posedge clk) begin
		if (emit) begin
			rsp_status_q <= emit_status;
			rsp_value_q  <= emit_value;
			rsp_last_q   <= emit_last;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.out_value   = rsp_value_q;
	assign rsp.last_result = rsp_last_q;

endmodule

>>> sim/tb.sv
// Self-checking testbench for bounded_deque_engine_core: a directed table, then random requests.
// Uses bde_pkg for codes and widths, bde_if for the channels, and the RTL of the core.
`timescale 1ns / 1ps

module tb;

	// Request codes that the core accepts and drops without a result.
	localparam logic [2:0] REQ_SPARE_A = 3'd5;
	localparam logic [2:0] REQ_SPARE_B = 3'd6;
	localparam logic [2:0] REQ_SPARE_C = 3'd7;

	localparam int RANDOM_ITEMS = 120;
	localparam int CALM_ITEMS   = 30;
	localparam int DRAIN_CYCLES = 20;
	localparam int MAX_REPORTS  = 10;

	// One result word as the rsp channel carries it.
	typedef struct {
		logic [1:0]                        status;
		logic signed [bde_pkg::DATA_W-1:0] value;
		logic                              last;
	} rsp_word_t;

	// One row of the directed table; typed rows carry their own single answer.
	typedef struct {
		logic [2:0]                        code;
		logic signed [bde_pkg::DATA_W-1:0] value;
		int                                reps;
		bit                                typed;
		logic [1:0]                        typed_status;
	} stim_row_t;

	logic clk;
	logic arst_n;

	bde_req_if req_ch();
	bde_rsp_if rsp_ch();

	bounded_deque_engine_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Shadow copy of the deque and the words it is expected to produce.
	logic signed [bde_pkg::DATA_W-1:0] deque_copy [bde_pkg::DEPTH];
	int                                copy_head;
	int                                copy_fill;
	rsp_word_t                         expected_words[$];
	stim_row_t                         stim_table[$];

	bit        calm_phase;
	bit        growing;
	int        stall_left;
	int        error_count;
	int        requests_sent;
	int        words_checked;
	int        full_rejects;
	int        empty_hits;
	int        displays_full;
	rsp_word_t want;
	rsp_word_t typed_word;
	int        rep;
	int        counted;
	int        roll;
	logic [2:0]                        pick_code;
	logic signed [bde_pkg::DATA_W-1:0] pick_value;

	// Clock generation.
	always #5 clk = ~clk;

	// Work out the words one accepted request causes and update the shadow deque.
	task automatic predict_deque(input logic [2:0] code,
			input logic signed [bde_pkg::DATA_W-1:0] val);
		rsp_word_t w;
		int k;
		w.status = bde_pkg::STAT_OK;
		w.value  = '0;
		w.last   = 1'b1;
		case (code)
			bde_pkg::OP_INS_FRONT, bde_pkg::OP_INS_BACK: begin
				if (copy_fill == bde_pkg::DEPTH) begin
					w.status = bde_pkg::STAT_FULL;
					full_rejects++;
				end else if (code == bde_pkg::OP_INS_FRONT) begin
					copy_head = (copy_head + bde_pkg::DEPTH - 1) % bde_pkg::DEPTH;
					deque_copy[copy_head] = val;
					copy_fill++;
				end else begin
					deque_copy[(copy_head + copy_fill) % bde_pkg::DEPTH] = val;
					copy_fill++;
				end
				expected_words.push_back(w);
			end
			bde_pkg::OP_DEL_FRONT, bde_pkg::OP_DEL_BACK: begin
				if (copy_fill == 0) begin
					w.status = bde_pkg::STAT_EMPTY;
					empty_hits++;
				end else begin
					if (code == bde_pkg::OP_DEL_FRONT) begin
						copy_head = (copy_head + 1) % bde_pkg::DEPTH;
					end
					copy_fill--;
				end
				expected_words.push_back(w);
			end
			bde_pkg::OP_DISPLAY: begin
				if (copy_fill == 0) begin
					w.status = bde_pkg::STAT_EMPTY;
					empty_hits++;
					expected_words.push_back(w);
				end else begin
					if (copy_fill == bde_pkg::DEPTH) begin
						displays_full++;
					end
					for (k = 0; k < copy_fill; k++) begin
						w.value = deque_copy[(copy_head + k) % bde_pkg::DEPTH];
						w.last  = (k == copy_fill - 1);
						expected_words.push_back(w);
					end
				end
			end
			default: begin
			end
		endcase
	endtask

	// Present one request word and hold it until the core takes it.
	task automatic send_request(input logic [2:0] code,
			input logic signed [bde_pkg::DATA_W-1:0] val);
		@(negedge clk);
		req_ch.valid      <= 1'b1;
		req_ch.req_type   <= code;
		req_ch.item_value <= val;
		@(posedge clk);
		while (!req_ch.ready) begin
			@(posedge clk);
		end
		predict_deque(code, val);
		requests_sent++;
	endtask

	// Drop valid and leave the request channel idle; n sets the length of the pause.
	task automatic pause_sender(input int n);
		@(negedge clk);
		req_ch.valid <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	task automatic add_row(input logic [2:0] code,
			input logic signed [bde_pkg::DATA_W-1:0] val,
			input int reps, input bit typed, input logic [1:0] status);
		stim_row_t r;
		r.code         = code;
		r.value        = val;
		r.reps         = reps;
		r.typed        = typed;
		r.typed_status = status;
		stim_table.push_back(r);
	endtask

	// Random value with a bias toward the extremes.
	function automatic logic signed [bde_pkg::DATA_W-1:0] random_value();
		logic signed [bde_pkg::DATA_W-1:0] v;
		case ($urandom_range(0, 7))
			0: v = 32'h7FFF_FFFF;
			1: v = 32'h8000_0000;
			2: v = -1;
			3: v = '0;
			default: v = $urandom;
		endcase
		return v;
	endfunction

	// Receiver: ready drops in bursts whose length stall_left draws at random, never in the calm phase.
	always @(negedge clk) begin
		if (calm_phase) begin
			stall_left = 0;
			rsp_ch.ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			rsp_ch.ready <= 1'b0;
		end else if ($urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(0, 10);
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	// Compare every accepted result word with the oldest expected one.
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			words_checked++;
			if (expected_words.size() == 0) begin
				error_count++;
				if (error_count <= MAX_REPORTS) begin
					$display("ERROR %0t: unexpected word status=%0d value=%0d last=%0b",
						$realtime, rsp_ch.status, rsp_ch.out_value, rsp_ch.last_result);
				end
			end else begin
				want = expected_words.pop_front();
				if (rsp_ch.status !== want.status || rsp_ch.out_value !== want.value ||
						rsp_ch.last_result !== want.last) begin
					error_count++;
					if (error_count <= MAX_REPORTS) begin
						$display("ERROR %0t: expected status=%0d value=%0d last=%0b,",
							$realtime, want.status, want.value, want.last,
							" got status=%0d value=%0d last=%0b",
							rsp_ch.status, rsp_ch.out_value, rsp_ch.last_result);
					end
				end
			end
		end
	end

	// Run limit.
	initial begin
		#2_000_000;
		$display("bounded_deque_engine_core: mismatch");
		$finish;
	end

	// Stimulus.
	initial begin
		clk               = 1'b0;
		arst_n            = 1'b0;
		req_ch.valid      = 1'b0;
		req_ch.req_type   = '0;
		req_ch.item_value = '0;
		rsp_ch.ready      = 1'b0;
		calm_phase        = 1'b0;
		growing           = 1'b1;
		stall_left        = 0;
		error_count       = 0;
		requests_sent     = 0;
		words_checked     = 0;
		full_rejects      = 0;
		empty_hits        = 0;
		displays_full     = 0;
		copy_head         = 0;
		copy_fill         = 0;

		// Empty deque right after reset, then both extremes at both ends.
		add_row(bde_pkg::OP_DEL_FRONT, '0, 1, 1'b1, bde_pkg::STAT_EMPTY);
		add_row(bde_pkg::OP_DEL_BACK, 32'h1234_5678, 1, 1'b1, bde_pkg::STAT_EMPTY);
		add_row(bde_pkg::OP_DISPLAY, '0, 1, 1'b1, bde_pkg::STAT_EMPTY);
		add_row(REQ_SPARE_A, -1, 1, 1'b0, bde_pkg::STAT_OK);
		add_row(bde_pkg::OP_INS_BACK, 32'h7FFF_FFFF, 1, 1'b1, bde_pkg::STAT_OK);
		add_row(bde_pkg::OP_INS_FRONT, 32'h8000_0000, 1, 1'b1, bde_pkg::STAT_OK);
		add_row(bde_pkg::OP_DISPLAY, '0, 1, 1'b0, bde_pkg::STAT_OK);
		add_row(REQ_SPARE_B, 32'h7FFF_FFFF, 1, 1'b0, bde_pkg::STAT_OK);
		// Fill to the limit, then try to insert at both ends.
		add_row(bde_pkg::OP_INS_BACK, -1, 1, 1'b1, bde_pkg::STAT_OK);
		add_row(bde_pkg::OP_INS_FRONT, '0, 1, 1'b1, bde_pkg::STAT_OK);
		add_row(bde_pkg::OP_INS_BACK, 32'h5A5A_5A5A, 6, 1'b1, bde_pkg::STAT_OK);
		add_row(bde_pkg::OP_INS_FRONT, 32'hA5A5_A5A5, 6, 1'b1, bde_pkg::STAT_OK);
		add_row(bde_pkg::OP_INS_BACK, 32'h0000_0001, 1, 1'b1, bde_pkg::STAT_FULL);
		add_row(bde_pkg::OP_INS_FRONT, -2, 1, 1'b1, bde_pkg::STAT_FULL);
		add_row(bde_pkg::OP_DISPLAY, '0, 1, 1'b0, bde_pkg::STAT_OK);
		add_row(REQ_SPARE_C, '0, 1, 1'b0, bde_pkg::STAT_OK);
		// Drain from both ends; the front index is kept once empty.
		add_row(bde_pkg::OP_DEL_FRONT, '0, 8, 1'b1, bde_pkg::STAT_OK);
		add_row(bde_pkg::OP_DEL_BACK, '0, 8, 1'b1, bde_pkg::STAT_OK);
		add_row(bde_pkg::OP_DEL_BACK, '0, 1, 1'b1, bde_pkg::STAT_EMPTY);
		add_row(bde_pkg::OP_DISPLAY, '0, 1, 1'b1, bde_pkg::STAT_EMPTY);
		add_row(bde_pkg::OP_INS_BACK, 32'h0F0F_0F0F, 1, 1'b0, bde_pkg::STAT_OK);
		add_row(bde_pkg::OP_INS_FRONT, 32'h7FFF_FFFE, 1, 1'b0, bde_pkg::STAT_OK);
		add_row(bde_pkg::OP_DISPLAY, '0, 1, 1'b0, bde_pkg::STAT_OK);
		add_row(bde_pkg::OP_DEL_BACK, '0, 1, 1'b0, bde_pkg::STAT_OK);
		add_row(bde_pkg::OP_DISPLAY, '0, 1, 1'b0, bde_pkg::STAT_OK);

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed table; rows with a typed answer replace the predicted word.
		foreach (stim_table[r]) begin
			for (rep = 0; rep < stim_table[r].reps; rep++) begin
				if ($urandom_range(0, 4) == 0) begin
					pause_sender($urandom_range(1, 11));
				end
				send_request(stim_table[r].code, stim_table[r].value);
				if (stim_table[r].typed) begin
					typed_word.status = stim_table[r].typed_status;
					typed_word.value  = '0;
					typed_word.last   = 1'b1;
					expected_words[expected_words.size() - 1] = typed_word;
				end
			end
		end

		// Random requests in growing and shrinking runs so the deque fills and empties.
		counted = 0;
		while (counted < RANDOM_ITEMS) begin
			calm_phase = (counted >= RANDOM_ITEMS - CALM_ITEMS);
			if (counted == RANDOM_ITEMS / 2) begin
				pause_sender(1);
				while (expected_words.size() != 0) begin
					@(posedge clk);
				end
			end
			if (copy_fill == bde_pkg::DEPTH && $urandom_range(0, 2) == 0) begin
				growing = 1'b0;
			end else if (copy_fill == 0 && $urandom_range(0, 2) == 0) begin
				growing = 1'b1;
			end else if ($urandom_range(0, 24) == 0) begin
				growing = !growing;
			end

			roll       = $urandom_range(0, 99);
			pick_value = random_value();
			if (roll < 3) begin
				case ($urandom_range(0, 2))
					0: pick_code = REQ_SPARE_A;
					1: pick_code = REQ_SPARE_B;
					default: pick_code = REQ_SPARE_C;
				endcase
			end else if (roll < 15) begin
				pick_code = bde_pkg::OP_DISPLAY;
			end else if (roll < (growing ? 75 : 40)) begin
				pick_code = $urandom_range(0, 1) ? bde_pkg::OP_INS_FRONT : bde_pkg::OP_INS_BACK;
			end else begin
				pick_code = $urandom_range(0, 1) ? bde_pkg::OP_DEL_FRONT : bde_pkg::OP_DEL_BACK;
			end

			if (!calm_phase && $urandom_range(0, 5) == 0) begin
				pause_sender($urandom_range(1, 11));
			end
			send_request(pick_code, pick_value);
			if (roll >= 3) begin
				counted++;
			end
		end

		// Let every expected word arrive, then watch for strays.
		pause_sender(1);
		while (expected_words.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d requests, checked %0d result words, %0d errors.",
			requests_sent, words_checked, error_count);
		$display("Saw %0d full rejects, %0d empty results, %0d displays of a full deque.",
			full_rejects, empty_hits, displays_full);
		if (error_count == 0) begin
			$display("bounded_deque_engine_core: match");
		end else begin
			$display("bounded_deque_engine_core: mismatch");
		end
		$finish;
	end

endmodule
